>>> sv/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the HTML tag stripper
// Byte codes, pattern lengths, pattern lookup functions and the item struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  // special bytes
  localparam logic [7:0] CH_LT = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT = 8'h3E;  // '>'

  // pattern lengths
  localparam logic [3:0] SCRIPT_OPEN_LEN  = 4'd7;  // "<script"
  localparam logic [3:0] STYLE_OPEN_LEN   = 4'd6;  // "<style"
  localparam logic [3:0] SCRIPT_CLOSE_LEN = 4'd9;  // "</script>"
  localparam logic [3:0] STYLE_CLOSE_LEN  = 4'd8;  // "</style>"

  // one byte of text travelling between stages
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } hts_item_t;

  // expected byte of "<script" at a position
  function automatic logic [7:0] script_open_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_LT;
      3'd1:    ch = 8'h73;  // s
      3'd2:    ch = 8'h63;  // c
      3'd3:    ch = 8'h72;  // r
      3'd4:    ch = 8'h69;  // i
      3'd5:    ch = 8'h70;  // p
      3'd6:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected byte of "<style" at a position
  function automatic logic [7:0] style_open_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_LT;
      3'd1:    ch = 8'h73;  // s
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h79;  // y
      3'd4:    ch = 8'h6C;  // l
      3'd5:    ch = 8'h65;  // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected byte of "</script>" at a position
  function automatic logic [7:0] script_close_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = CH_LT;
      4'd1:    ch = 8'h2F;  // /
      4'd2:    ch = 8'h73;  // s
      4'd3:    ch = 8'h63;  // c
      4'd4:    ch = 8'h72;  // r
      4'd5:    ch = 8'h69;  // i
      4'd6:    ch = 8'h70;  // p
      4'd7:    ch = 8'h74;  // t
      4'd8:    ch = CH_GT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected byte of "</style>" at a position
  function automatic logic [7:0] style_close_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = CH_LT;
      4'd1:    ch = 8'h2F;  // /
      4'd2:    ch = 8'h73;  // s
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h79;  // y
      4'd5:    ch = 8'h6C;  // l
      4'd6:    ch = 8'h65;  // e
      4'd7:    ch = CH_GT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/hts_if.sv
// ----------------------------------------------------------------------------
// hts_if: stream channels of the HTML tag stripper
// Text byte channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

// text byte channel
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// result channel
interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       keep;
  logic       last_of_text;

  modport source (output valid, output out_byte, output keep, output last_of_text,
                  input ready);
  modport sink   (input valid, input out_byte, input keep, input last_of_text,
                  output ready);
endinterface

`default_nettype wire

>>> sv/hts_scan.sv
// ----------------------------------------------------------------------------
// hts_scan: tag and section tracker
// Holds the parser state and decides per byte whether it is visible text.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_scan
  import hts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,    // the byte below moves on this cycle
  input  wire hts_item_t item,
  output logic           keep
);

  logic       tag_r, tag_nxt;
  logic       before_r, before_nxt;
  logic       script_r, script_nxt;
  logic       style_r, style_nxt;
  logic [2:0] so_r, so_nxt;
  logic [2:0] st_r, st_nxt;
  logic [3:0] cl_r, cl_nxt;

  logic [7:0] b;
  logic       is_lt;
  logic [3:0] cl_len;
  logic [7:0] cl_exp;
  logic [3:0] cl_adv;
  logic [2:0] so_adv;
  logic [2:0] st_adv;
  logic       so_done;
  logic       st_done;

  assign b     = item.text_byte;
  assign is_lt = (b == CH_LT);

  // match counters: advance on the expected byte, restart on '<'
  always_comb begin
    cl_len = script_r ? SCRIPT_CLOSE_LEN : STYLE_CLOSE_LEN;
    cl_exp = script_r ? script_close_char(cl_r) : style_close_char(cl_r);
    if ((cl_r < cl_len) && (b == cl_exp)) begin
      cl_adv = cl_r + 4'd1;
    end else begin
      cl_adv = {3'd0, is_lt};
    end
    if (({1'b0, so_r} < SCRIPT_OPEN_LEN) && (b == script_open_char(so_r))) begin
      so_adv = so_r + 3'd1;
    end else begin
      so_adv = {2'd0, is_lt};
    end
    if (({1'b0, st_r} < STYLE_OPEN_LEN) && (b == style_open_char(st_r))) begin
      st_adv = st_r + 3'd1;
    end else begin
      st_adv = {2'd0, is_lt};
    end
    so_done = ({1'b0, so_adv} == SCRIPT_OPEN_LEN);
    st_done = ({1'b0, st_adv} == STYLE_OPEN_LEN);
  end

  // next state and keep decision
  always_comb begin
    tag_nxt    = tag_r;
    before_nxt = before_r;
    script_nxt = script_r;
    style_nxt  = style_r;
    so_nxt     = so_r;
    st_nxt     = st_r;
    cl_nxt     = cl_r;
    keep       = 1'b0;
    if (script_r || style_r) begin
      // inside a section: only look for its closing tag
      cl_nxt = cl_adv;
      if (cl_adv == cl_len) begin
        script_nxt = 1'b0;
        style_nxt  = 1'b0;
        cl_nxt     = 4'd0;
      end
    end else begin
      so_nxt = so_adv;
      st_nxt = st_adv;
      if (is_lt) begin
        before_nxt = tag_r;
        tag_nxt    = 1'b1;
      end else if (b == CH_GT) begin
        tag_nxt = 1'b0;
      end else begin
        keep = !tag_r;
      end
      if (so_done) begin
        script_nxt = 1'b1;
      end else if (st_done) begin
        style_nxt = 1'b1;
      end
      if (so_done || st_done) begin
        tag_nxt = before_nxt;
        so_nxt  = 3'd0;
        st_nxt  = 3'd0;
        cl_nxt  = 4'd0;
        keep    = 1'b0;
      end
    end
  end

  // state registers, cleared after the last byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.end_of_text)) begin
      tag_r    <= 1'b0;
      before_r <= 1'b0;
      script_r <= 1'b0;
      style_r  <= 1'b0;
      so_r     <= 3'd0;
      st_r     <= 3'd0;
      cl_r     <= 4'd0;
    end else if (step) begin
      tag_r    <= tag_nxt;
      before_r <= before_nxt;
      script_r <= script_nxt;
      style_r  <= style_nxt;
      so_r     <= so_nxt;
      st_r     <= st_nxt;
      cl_r     <= cl_nxt;
    end
  end

  // never in both kinds of section
  a_one_section: assert property (@(posedge clk) disable iff (!rst_n)
    !(script_r && style_r))
    else $error("script and style sections open together");

  // open counters stay idle inside a section
  a_open_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (script_r || style_r) |-> (so_r == 3'd0 && st_r == 3'd0))
    else $error("open match counter moved inside a section");

  // close counter stays below the closing pattern length
  a_close_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cl_r < SCRIPT_CLOSE_LEN) && (!style_r || cl_r < STYLE_CLOSE_LEN))
    else $error("close match counter out of range");

  // end of text puts everything back to reset
  a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.end_of_text) |=>
      (!tag_r && !before_r && !script_r && !style_r && so_r == 3'd0 &&
       st_r == 3'd0 && cl_r == 4'd0))
    else $error("state not cleared after end of text");

endmodule

`default_nettype wire

>>> sv/html_tag_stripper.sv
// ----------------------------------------------------------------------------
// html_tag_stripper: visible text marker for an HTML byte stream
// Input register, per-byte tag/section tracking and a result register.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, unless the result channel stalls, and returns
// every byte in order with a keep flag that is high for visible text: bytes
// inside tags and inside script and style sections are marked dropped.
// Sustained rate is one byte per clock while the result channel is ready.
// The input register captures a byte at its transfer edge; the result
// register then takes it together with the keep flag from the tracker's
// state update, and presents it on the result channel. A stalled result
// holds the input register, which then holds off the text channel. Mark
// the final byte of a text with end_of_text; the tracker returns to its
// reset state right after it.
`default_nettype none

module html_tag_stripper
  import hts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  hts_in_if.sink    in_ch,
  hts_out_if.source out_ch
);

  logic       s1_valid_r;
  hts_item_t  s1_item_r;
  logic       s1_move;
  logic       keep;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_keep_r;
  logic       out_last_r;

  // stage one advances when the result register is free or being drained
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.text_byte   <= in_ch.text_byte;
      s1_item_r.end_of_text <= in_ch.end_of_text;
    end
  end

  // tracker
  hts_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .item  (s1_item_r),
    .keep  (keep)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_byte_r <= s1_item_r.text_byte;
      out_keep_r <= keep;
      out_last_r <= s1_item_r.end_of_text;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.keep         = out_keep_r;
  assign out_ch.last_of_text = out_last_r;

endmodule

`default_nettype wire
